### sv/tracker_packet_parser_responder_assert.svh
// Assertion macros used by the tracker emitter module.
// Each check is clocked on clk_i and disabled while rst_ni is low.
`ifndef TRACKER_PACKET_PARSER_RESPONDER_ASSERT_SVH
`define TRACKER_PACKET_PARSER_RESPONDER_ASSERT_SVH

// Same-cycle implication
`define TPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tpp_pkg.sv
package tpp_pkg;

  // Framing bytes
  localparam logic [7:0] StartByte = 8'h78;
  localparam logic [7:0] CrByte    = 8'h0d;
  localparam logic [7:0] LfByte    = 8'h0a;
  localparam logic [7:0] AckLen    = 8'h05;
  localparam logic [15:0] CrcInit  = 16'hffff;
  localparam logic [15:0] CrcPoly  = 16'h8408;

  // Protocol codes
  localparam logic [7:0] ProtoLogin     = 8'h01;
  localparam logic [7:0] ProtoHeartbeat = 8'h13;
  localparam logic [7:0] ProtoLocation  = 8'h12;
  localparam logic [7:0] ProtoAlarm     = 8'h16;

  // Result kinds
  localparam logic [2:0] KindAck       = 3'd0;
  localparam logic [2:0] KindLogin     = 3'd1;
  localparam logic [2:0] KindHeartbeat = 3'd2;
  localparam logic [2:0] KindLocation  = 3'd3;
  localparam logic [2:0] KindAlarm     = 3'd4;

  // Items per event: one record, plus ten ack bytes when acknowledged
  localparam logic [3:0] CntRecord  = 4'd1;
  localparam logic [3:0] CntWithAck = 4'd11;

  // One byte of CRC-16/X.25 (reflected)
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // CRC state after the constant length byte of an ack
  localparam logic [15:0] AckCrcSeed = crc_feed(CrcInit, AckLen);

  // Completed-packet event, parser to emitter
  typedef struct packed {
    logic [2:0]         kind;
    logic               has_ack;
    logic [63:0]        terminal_id;
    logic [47:0]        date_time;
    logic [7:0]         satellites;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic [7:0]         speed;
    logic               crc_ok;
    logic [7:0]         sensor_flags;
    logic [15:0]        alarm_levels;
    logic [7:0]         ack_proto;
    logic [15:0]        ack_serial;
    logic [15:0]        ack_crc;
  } event_t;

  // One result item
  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         ack_byte;
    logic               last;
    logic [63:0]        terminal_id;
    logic [47:0]        date_time;
    logic [7:0]         satellites;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic [7:0]         speed;
    logic               crc_ok;
    logic [7:0]         sensor_flags;
    logic [15:0]        alarm_levels;
  } item_t;

endpackage

### sv/tpp_parser.sv
module tpp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         rx_byte_i,
  output logic               ev_valid_o,
  output tpp_pkg::event_t    ev_o
);

  // Frame phases
  localparam logic [1:0] PhHunt   = 2'd0;
  localparam logic [1:0] PhOne    = 2'd1;
  localparam logic [1:0] PhPacket = 2'd2;

  // Byte positions inside a packet
  localparam logic [5:0] PosProto     = 6'd1;
  localparam logic [5:0] PosFirst     = 6'd2;
  localparam logic [5:0] PosIdEnd     = 6'd9;
  localparam logic [5:0] PosLoginEnd  = 6'd11;
  localparam logic [5:0] PosHbSerHi   = 6'd7;
  localparam logic [5:0] PosHbEnd     = 6'd8;
  localparam logic [5:0] PosTimeEnd   = 6'd7;
  localparam logic [5:0] PosSats      = 6'd8;
  localparam logic [5:0] PosLatEnd    = 6'd12;
  localparam logic [5:0] PosLonEnd    = 6'd16;
  localparam logic [5:0] PosSpeed     = 6'd17;
  localparam logic [5:0] PosLevelHi   = 6'd30;
  localparam logic [5:0] PosLevelLo   = 6'd31;
  localparam logic [5:0] PosLocCrc    = 6'd30;
  localparam logic [5:0] PosAlarmCrc  = 6'd36;

  logic [1:0]  phase_q, phase_d;
  logic [5:0]  idx_q, idx_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic [15:0] serial_q, serial_d;
  logic [15:0] ack_crc_q, ack_crc_d;
  logic [63:0] id_q, id_d;
  logic [47:0] time_q, time_d;
  logic [7:0]  sats_q, sats_d;
  logic [31:0] lat_q, lat_d;
  logic [31:0] lon_q, lon_d;
  logic [7:0]  speed_q, speed_d;
  logic [15:0] levels_q, levels_d;
  logic [31:0] hlat_q, hlat_d;
  logic [31:0] hlon_q, hlon_d;
  logic [7:0]  hspeed_q, hspeed_d;
  logic [7:0]  hsensor_q, hsensor_d;

  logic        done;
  logic        alarm;
  logic        ok;
  logic [5:0]  limit;
  logic [5:0]  crc_at;
  logic [7:0]  b;

  assign b     = rx_byte_i;
  assign alarm = (proto_q == tpp_pkg::ProtoAlarm);

  // Next state for one accepted byte
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    proto_d   = proto_q;
    crc_d     = crc_q;
    rcrc_d    = rcrc_q;
    serial_d  = serial_q;
    ack_crc_d = ack_crc_q;
    id_d      = id_q;
    time_d    = time_q;
    sats_d    = sats_q;
    lat_d     = lat_q;
    lon_d     = lon_q;
    speed_d   = speed_q;
    levels_d  = levels_q;
    hlat_d    = hlat_q;
    hlon_d    = hlon_q;
    hspeed_d  = hspeed_q;
    hsensor_d = hsensor_q;
    done      = 1'b0;
    ok        = 1'b0;
    ev_o      = '0;
    limit     = (alarm && idx_q >= PosFirst) ? PosAlarmCrc : PosLocCrc;
    crc_at    = alarm ? PosAlarmCrc : PosLocCrc;

    unique case (phase_q)
      PhHunt: begin
        if (b == tpp_pkg::StartByte) phase_d = PhOne;
      end
      PhOne: begin
        if (b == tpp_pkg::StartByte) begin
          phase_d = PhPacket;
          idx_d   = '0;
          crc_d   = tpp_pkg::CrcInit;
          rcrc_d  = '0;
        end else begin
          phase_d = PhHunt;
        end
      end
      PhPacket: begin
        if (idx_q < limit) crc_d = tpp_pkg::crc_feed(crc_q, b);

        if (idx_q == PosProto) begin
          // protocol byte: unknown codes drop the packet
          proto_d   = b;
          ack_crc_d = tpp_pkg::crc_feed(tpp_pkg::AckCrcSeed, b);
          if (b != tpp_pkg::ProtoLogin && b != tpp_pkg::ProtoHeartbeat &&
              b != tpp_pkg::ProtoLocation && b != tpp_pkg::ProtoAlarm) begin
            phase_d = PhHunt;
          end
        end else if (idx_q >= PosFirst) begin
          if (proto_q == tpp_pkg::ProtoLogin) begin
            // login: terminal id then serial number
            if (idx_q <= PosIdEnd) begin
              id_d = {id_q[55:0], b};
            end else if (idx_q <= PosLoginEnd) begin
              serial_d  = {serial_q[7:0], b};
              ack_crc_d = tpp_pkg::crc_feed(ack_crc_q, b);
            end
            if (idx_q == PosLoginEnd) begin
              done           = 1'b1;
              ev_o.kind      = tpp_pkg::KindLogin;
              ev_o.has_ack   = 1'b1;
              ev_o.terminal_id = id_q;
            end
          end else if (proto_q == tpp_pkg::ProtoHeartbeat) begin
            // heartbeat: sensor flags, then serial number
            if (idx_q == PosFirst) begin
              if (b[1]) hsensor_d = 8'd2;
              if (b[7]) hsensor_d = 8'd128;
            end else if (idx_q == PosHbSerHi || idx_q == PosHbEnd) begin
              serial_d  = {serial_q[7:0], b};
              ack_crc_d = tpp_pkg::crc_feed(ack_crc_q, b);
            end
            if (idx_q == PosHbEnd) begin
              done         = 1'b1;
              ev_o.kind    = tpp_pkg::KindHeartbeat;
              ev_o.has_ack = 1'b1;
            end
          end else begin
            // location or alarm: positional capture and CRC check
            if (idx_q <= PosTimeEnd)     time_d  = {time_q[39:0], b};
            else if (idx_q == PosSats)   sats_d  = alarm ? {4'h0, b[3:0]} : b;
            else if (idx_q <= PosLatEnd) lat_d   = {lat_q[23:0], b};
            else if (idx_q <= PosLonEnd) lon_d   = {lon_q[23:0], b};
            else if (idx_q == PosSpeed)  speed_d = b;
            if (alarm && (idx_q == PosLevelHi || idx_q == PosLevelLo)) begin
              levels_d = {levels_q[7:0], b};
            end
            if (idx_q == crc_at || idx_q == crc_at + 6'd1) begin
              rcrc_d = {rcrc_q[7:0], b};
            end
            if (idx_q == crc_at + 6'd1) begin
              done = 1'b1;
              ok   = (rcrc_d == ~crc_d);
              if (ok) begin
                hlat_d   = lat_q;
                hlon_d   = lon_q;
                hspeed_d = speed_q;
              end
              ev_o.kind         = alarm ? tpp_pkg::KindAlarm : tpp_pkg::KindLocation;
              ev_o.date_time    = time_q;
              ev_o.satellites   = sats_q;
              ev_o.crc_ok       = ok;
              ev_o.alarm_levels = alarm ? levels_d : 16'h0000;
            end
          end
        end

        if (done) begin
          phase_d = PhHunt;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      default: phase_d = PhHunt;
    endcase

    // held values and ack fields go with every event
    ev_o.latitude     = hlat_d;
    ev_o.longitude    = hlon_d;
    ev_o.speed        = hspeed_d;
    ev_o.sensor_flags = hsensor_d;
    ev_o.ack_proto    = proto_q;
    ev_o.ack_serial   = serial_d;
    ev_o.ack_crc      = ~ack_crc_d;
  end

  assign ev_valid_o = accept_i && done;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      idx_q     <= '0;
      proto_q   <= '0;
      crc_q     <= tpp_pkg::CrcInit;
      rcrc_q    <= '0;
      serial_q  <= '0;
      ack_crc_q <= tpp_pkg::CrcInit;
      id_q      <= '0;
      time_q    <= '0;
      sats_q    <= '0;
      lat_q     <= '0;
      lon_q     <= '0;
      speed_q   <= '0;
      levels_q  <= '0;
      hlat_q    <= '0;
      hlon_q    <= '0;
      hspeed_q  <= '0;
      hsensor_q <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      proto_q   <= proto_d;
      crc_q     <= crc_d;
      rcrc_q    <= rcrc_d;
      serial_q  <= serial_d;
      ack_crc_q <= ack_crc_d;
      id_q      <= id_d;
      time_q    <= time_d;
      sats_q    <= sats_d;
      lat_q     <= lat_d;
      lon_q     <= lon_d;
      speed_q   <= speed_d;
      levels_q  <= levels_d;
      hlat_q    <= hlat_d;
      hlon_q    <= hlon_d;
      hspeed_q  <= hspeed_d;
      hsensor_q <= hsensor_d;
    end
  end

endmodule

### sv/tpp_emitter.sv
`include "tracker_packet_parser_responder_assert.svh"

module tpp_emitter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ev_valid_i,
  input  tpp_pkg::event_t    ev_i,
  output logic               ev_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tpp_pkg::item_t     out_o
);

  tpp_pkg::event_t ev_q, ev_d;
  tpp_pkg::item_t  out_q, out_d;
  tpp_pkg::item_t  item;
  logic [3:0]      cnt_q, cnt_d;
  logic [3:0]      pos_q, pos_d;
  logic            out_valid_q, out_valid_d;
  logic            can_load;
  logic [7:0]      ack_byte;

  assign can_load   = !out_valid_q || out_ready_i;
  assign ev_ready_o = (cnt_q == 4'd0) || (cnt_q == 4'd1 && can_load);

  // Ack frame byte at the current position (record is position 0)
  always_comb begin
    unique case (pos_q)
      4'd1:    ack_byte = tpp_pkg::StartByte;
      4'd2:    ack_byte = tpp_pkg::StartByte;
      4'd3:    ack_byte = tpp_pkg::AckLen;
      4'd4:    ack_byte = ev_q.ack_proto;
      4'd5:    ack_byte = ev_q.ack_serial[15:8];
      4'd6:    ack_byte = ev_q.ack_serial[7:0];
      4'd7:    ack_byte = ev_q.ack_crc[15:8];
      4'd8:    ack_byte = ev_q.ack_crc[7:0];
      4'd9:    ack_byte = tpp_pkg::CrByte;
      4'd10:   ack_byte = tpp_pkg::LfByte;
      default: ack_byte = 8'h00;
    endcase
  end

  // Item built from the held event
  always_comb begin
    item      = '0;
    item.last = (cnt_q == 4'd1);
    if (pos_q == 4'd0) begin
      item.kind         = ev_q.kind;
      item.terminal_id  = ev_q.terminal_id;
      item.date_time    = ev_q.date_time;
      item.satellites   = ev_q.satellites;
      item.latitude     = ev_q.latitude;
      item.longitude    = ev_q.longitude;
      item.speed        = ev_q.speed;
      item.crc_ok       = ev_q.crc_ok;
      item.sensor_flags = ev_q.sensor_flags;
      item.alarm_levels = ev_q.alarm_levels;
    end else begin
      item.kind     = tpp_pkg::KindAck;
      item.ack_byte = ack_byte;
    end
  end

  // Sequencing: drain the held event into the output register
  always_comb begin
    ev_d        = ev_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (can_load) begin
      if (cnt_q != 4'd0) begin
        out_d       = item;
        out_valid_d = 1'b1;
        cnt_d       = cnt_q - 4'd1;
        pos_d       = pos_q + 4'd1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (ev_valid_i) begin
      ev_d  = ev_i;
      cnt_d = ev_i.has_ack ? tpp_pkg::CntWithAck : tpp_pkg::CntRecord;
      pos_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ev_q  <= ev_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `TPP_ASSERT_NOW(a_no_overwrite, ev_valid_i, cnt_q == 4'd0 || (cnt_q == 4'd1 && can_load), "event overwrote pending items")
  `TPP_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= tpp_pkg::CntWithAck, "item count out of range")
  `TPP_ASSERT_NOW(a_pos_loc_last, out_valid_q && (out_q.kind == tpp_pkg::KindLocation || out_q.kind == tpp_pkg::KindAlarm), out_q.last, "position record not last")
  `TPP_ASSERT_NEXT(a_drain_idle, out_valid_q && out_ready_i && cnt_q == 4'd0 && !ev_valid_i, !out_valid_q, "output valid without pending item")

endmodule

### sv/tracker_packet_parser_responder.sv
// Tracker packet parser and responder.
// Slave stream: one received byte per item in s_axis_tdata_i[7:0]. The parser hunts
// for the 0x78 0x78 start pair, tracks the CRC-16/X.25 and captures fields.
// Master stream: result items. tuser carries the kind (ack byte, login, heartbeat,
// location, alarm); tlast marks the final item caused by one input byte.
// Login and heartbeat packets give a record followed by a 10-byte acknowledge
// (11 items); location and alarm packets give one record with a CRC verdict.
// The byte that completes a packet loads the event register; its result then goes
// to the output register.
// Throughput: one byte per cycle while tready is high. The emitter holds one pending
// event; tready drops while more than one item of an earlier event is to be sent,
// or while its last item waits on a full output register, so ack bursts stall input.
// A stalled receiver holds the output register; input keeps flowing until a
// second event would be needed.
// Reset (asynchronous, active low) returns to hunting for a start pair and clears
// held position, speed and sensor flags; the output stream is empty.
module tracker_packet_parser_responder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] rx_byte
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [7:0] ack_byte, [71:8] terminal_id, [119:72] date_time, [127:120] satellites,
  // [159:128] latitude, [191:160] longitude, [199:192] speed, [200] crc_ok,
  // [208:201] sensor_flags, [224:209] alarm_levels, [231:225] zero
  output logic [231:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o,   // [2:0] out_kind
  output logic         m_axis_tlast_o    // last item for the input byte
);

  logic            accept;
  logic            ev_valid;
  logic            ev_ready;
  tpp_pkg::event_t ev;
  tpp_pkg::item_t  item;

  assign accept          = s_axis_tvalid_i && ev_ready;
  assign s_axis_tready_o = ev_ready;

  tpp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (s_axis_tdata_i),
    .ev_valid_o (ev_valid),
    .ev_o       (ev)
  );

  tpp_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (ev_valid),
    .ev_i        (ev),
    .ev_ready_o  (ev_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (item)
  );

  // Output packing
  assign m_axis_tuser_o = item.kind;
  assign m_axis_tlast_o = item.last;
  assign m_axis_tdata_o = {7'h00, item.alarm_levels, item.sensor_flags, item.crc_ok,
                           item.speed, item.longitude, item.latitude, item.satellites,
                           item.date_time, item.terminal_id, item.ack_byte};

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // Run shape
  localparam int NDIR          = 13;
  localparam int RAND_BYTES    = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int ACK_ITEMS     = 10;
  // Limit of 3 ms; the worst case (every byte gapped, slow receiver, acknowledge
  // bursts, one long hold-off) stays well inside it.
  localparam int LIMIT_NS      = 3_000_000;

  // Heartbeat flag values
  localparam logic [7:0] FLAG_ENGINE_ON = 8'h02;
  localparam logic [7:0] FLAG_CUT       = 8'h80;

  typedef enum logic [1:0] {PH_HUNT, PH_ONE, PH_PACKET} phase_e;
  typedef enum logic [2:0] {PK_LOGIN, PK_HEART, PK_LOC, PK_ALARM, PK_UNKNOWN, PK_NOISE} shape_e;
  typedef logic [7:0] byte_q_t [$];

  // One packet to send; rec holds a typed-in record where pinned is set
  typedef struct packed {
    shape_e          shape;
    logic            rnd;
    logic [7:0]      fill;
    logic [7:0]      flag;
    logic [31:0]     lat;
    logic [31:0]     lon;
    logic            bad_crc;
    logic            pinned;
    tpp_pkg::item_t  rec;
  } row_t;

  localparam row_t DIR_ROWS [NDIR] = '{
    // cleared state right after reset
    '{shape: PK_HEART, pinned: 1'b1,
      rec: '{kind: tpp_pkg::KindHeartbeat, default: '0}, default: '0},
    '{shape: PK_LOGIN, fill: 8'hff, pinned: 1'b1,
      rec: '{kind: tpp_pkg::KindLogin, terminal_id: '1, default: '0}, default: '0},
    // both flag bits: cut wins
    '{shape: PK_HEART, flag: 8'h82, pinned: 1'b1,
      rec: '{kind: tpp_pkg::KindHeartbeat, sensor_flags: 8'h80, default: '0},
      default: '0},
    // good CRC, extreme coordinates
    '{shape: PK_LOC, fill: 8'hff, lat: 32'h8000_0000, lon: 32'h7fff_ffff, pinned: 1'b1,
      rec: '{kind: tpp_pkg::KindLocation, date_time: '1, satellites: 8'hff,
             latitude: 32'h8000_0000, longitude: 32'h7fff_ffff, speed: 8'hff,
             crc_ok: 1'b1, sensor_flags: 8'h80, last: 1'b1, default: '0}, default: '0},
    // bad CRC: held values stay, satellites keep the low nibble
    '{shape: PK_ALARM, fill: 8'hff, lat: 32'h7fff_ffff, lon: 32'h8000_0000,
      bad_crc: 1'b1, pinned: 1'b1,
      rec: '{kind: tpp_pkg::KindAlarm, date_time: '1, satellites: 8'h0f,
             latitude: 32'h8000_0000, longitude: 32'h7fff_ffff, speed: 8'hff,
             crc_ok: 1'b0, sensor_flags: 8'h80, alarm_levels: 16'hffff,
             last: 1'b1, default: '0}, default: '0},
    '{shape: PK_HEART, fill: 8'h5a, flag: 8'h02, default: '0},
    // neither flag bit: flags unchanged
    '{shape: PK_HEART, fill: 8'ha5, flag: 8'h7d, default: '0},
    // unknown protocols are dropped
    '{shape: PK_UNKNOWN, flag: 8'h00, default: '0},
    '{shape: PK_UNKNOWN, fill: 8'h33, flag: 8'hff, default: '0},
    // half a start pair
    '{shape: PK_NOISE, fill: 8'h00, default: '0},
    // start bytes inside the packet body
    '{shape: PK_LOC, fill: 8'h78, lat: 32'h7878_7878, lon: 32'h1234_5678, default: '0},
    '{shape: PK_ALARM, fill: 8'h00, default: '0},
    '{shape: PK_HEART, flag: 8'h80, default: '0}
  };

  // DUT connections
  logic         clk_i;
  logic         rst_ni  = 1'b0;
  logic         s_valid = 1'b0;
  logic [7:0]   s_data  = '0;
  logic         m_ready = 1'b0;
  logic         s_ready;
  logic         m_valid;
  logic [231:0] m_data;
  logic [2:0]   m_user;
  logic         m_last;

  tracker_packet_parser_responder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  // Parser shadow state
  phase_e      ph         = PH_HUNT;
  logic [5:0]  pos        = '0;
  logic [7:0]  proto      = '0;
  logic [15:0] crc_run    = tpp_pkg::CrcInit;
  logic [15:0] crc_got    = '0;
  logic [15:0] ser        = '0;
  logic [63:0] id_sr      = '0;
  logic [47:0] time_sr    = '0;
  logic [7:0]  sats_cap   = '0;
  logic [31:0] lat_cap    = '0;
  logic [31:0] lon_cap    = '0;
  logic [7:0]  spd_cap    = '0;
  logic [15:0] lvl_cap    = '0;
  logic [31:0] lat_hold   = '0;
  logic [31:0] lon_hold   = '0;
  logic [7:0]  spd_hold   = '0;
  logic [7:0]  flags_hold = '0;

  // Items the parser owes, oldest first
  tpp_pkg::item_t due_items [$];
  logic           pin_valid = 1'b0;
  tpp_pkg::item_t pin_rec   = '0;

  int    bad_items  = 0;
  int    burst_left = 0;
  logic  hold_go    = 1'b0;

  // CRC-16/X.25, one bit at a time, LSB first
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = c >> 1;
      if (fb) c = c ^ tpp_pkg::CrcPoly;
    end
    return c;
  endfunction

  function automatic tpp_pkg::item_t held_record(input logic [2:0] kind);
    tpp_pkg::item_t it;
    it = '0;
    it.kind         = kind;
    it.latitude     = lat_hold;
    it.longitude    = lon_hold;
    it.speed        = spd_hold;
    it.sensor_flags = flags_hold;
    return it;
  endfunction

  // A typed-in record replaces the computed one
  function automatic void push_record(input tpp_pkg::item_t it);
    if (pin_valid) begin
      it = pin_rec;
      pin_valid = 1'b0;
    end
    due_items.push_back(it);
  endfunction

  function automatic void push_ack();
    logic [7:0]     fr [ACK_ITEMS];
    logic [15:0]    c;
    tpp_pkg::item_t it;
    fr = '{tpp_pkg::StartByte, tpp_pkg::StartByte, tpp_pkg::AckLen, proto,
           ser[15:8], ser[7:0], 8'h00, 8'h00, tpp_pkg::CrByte, tpp_pkg::LfByte};
    c = tpp_pkg::CrcInit;
    for (int i = 2; i < 6; i++) c = crc_step(c, fr[i]);
    c = ~c;
    fr[6] = c[15:8];
    fr[7] = c[7:0];
    for (int i = 0; i < ACK_ITEMS; i++) begin
      it = '0;
      it.kind     = tpp_pkg::KindAck;
      it.ack_byte = fr[i];
      it.last     = (i == ACK_ITEMS - 1);
      due_items.push_back(it);
    end
  endfunction

  // Advance the shadow parser by one accepted byte
  function automatic void track_rx_byte(input logic [7:0] b);
    tpp_pkg::item_t rec;
    logic [5:0]     lim;
    logic [5:0]     crc_at;
    logic           alarm;
    logic           ok;
    logic           done;
    logic           drop;
    done = 1'b0;
    drop = 1'b0;
    case (ph)
      PH_HUNT: begin
        if (b == tpp_pkg::StartByte) ph = PH_ONE;
      end
      PH_ONE: begin
        if (b == tpp_pkg::StartByte) begin
          ph      = PH_PACKET;
          pos     = '0;
          crc_run = tpp_pkg::CrcInit;
          crc_got = '0;
        end else begin
          ph = PH_HUNT;
        end
      end
      default: begin
        lim = (proto == tpp_pkg::ProtoAlarm && pos >= 2) ? 6'd36 : 6'd30;
        if (pos < lim) crc_run = crc_step(crc_run, b);
        if (pos == 6'd1) begin
          proto = b;
          drop  = !(b inside {tpp_pkg::ProtoLogin, tpp_pkg::ProtoHeartbeat,
                              tpp_pkg::ProtoLocation, tpp_pkg::ProtoAlarm});
        end else if (pos >= 6'd2) begin
          case (proto)
            tpp_pkg::ProtoLogin: begin
              if (pos <= 9) id_sr = {id_sr[55:0], b};
              else if (pos <= 11) ser = {ser[7:0], b};
              if (pos == 11) begin
                rec = held_record(tpp_pkg::KindLogin);
                rec.terminal_id = id_sr;
                push_record(rec);
                push_ack();
                done = 1'b1;
              end
            end
            tpp_pkg::ProtoHeartbeat: begin
              if (pos == 2) begin
                if (b[1]) flags_hold = FLAG_ENGINE_ON;
                if (b[7]) flags_hold = FLAG_CUT;
              end else if (pos == 7 || pos == 8) begin
                ser = {ser[7:0], b};
              end
              if (pos == 8) begin
                push_record(held_record(tpp_pkg::KindHeartbeat));
                push_ack();
                done = 1'b1;
              end
            end
            default: begin
              // location or alarm
              alarm  = (proto == tpp_pkg::ProtoAlarm);
              crc_at = alarm ? 6'd36 : 6'd30;
              if (pos <= 7) time_sr = {time_sr[39:0], b};
              else if (pos == 8) sats_cap = alarm ? {4'h0, b[3:0]} : b;
              else if (pos <= 12) lat_cap = {lat_cap[23:0], b};
              else if (pos <= 16) lon_cap = {lon_cap[23:0], b};
              else if (pos == 17) spd_cap = b;
              if (alarm && (pos == 30 || pos == 31)) lvl_cap = {lvl_cap[7:0], b};
              if (pos == crc_at || pos == crc_at + 1) crc_got = {crc_got[7:0], b};
              if (pos == crc_at + 1) begin
                ok = (crc_got == ~crc_run);
                if (ok) begin
                  lat_hold = lat_cap;
                  lon_hold = lon_cap;
                  spd_hold = spd_cap;
                end
                rec = held_record(alarm ? tpp_pkg::KindAlarm : tpp_pkg::KindLocation);
                rec.date_time  = time_sr;
                rec.satellites = sats_cap;
                rec.crc_ok     = ok;
                rec.last       = 1'b1;
                if (alarm) rec.alarm_levels = lvl_cap;
                push_record(rec);
                done = 1'b1;
              end
            end
          endcase
        end
        if (drop) begin
          ph = PH_HUNT;
        end else if (done) begin
          ph  = PH_HUNT;
          pos = '0;
        end else begin
          pos = pos + 6'd1;
        end
      end
    endcase
  endfunction

  // Byte sequence for one packet, start pair included
  function automatic void build_packet(input row_t r, output byte_q_t q);
    logic [7:0]  v;
    logic [7:0]  pr;
    logic [15:0] crc;
    logic [15:0] fcs;
    int          len;
    int          crc_at;
    logic        has_pos;
    q = {};
    if (r.shape == PK_NOISE) begin
      if (!r.rnd) begin
        q.push_back(tpp_pkg::StartByte);
        q.push_back(r.fill);
      end else begin
        if ($urandom_range(0, 1)) q.push_back(tpp_pkg::StartByte);
        repeat ($urandom_range(1, 4)) begin
          v = 8'($urandom_range(0, 255));
          if (v == tpp_pkg::StartByte) v = v + 8'd1;
          q.push_back(v);
        end
      end
      return;
    end
    case (r.shape)
      PK_LOGIN: begin pr = tpp_pkg::ProtoLogin;     len = 12; end
      PK_HEART: begin pr = tpp_pkg::ProtoHeartbeat; len = 9;  end
      PK_LOC:   begin pr = tpp_pkg::ProtoLocation;  len = 32; end
      PK_ALARM: begin pr = tpp_pkg::ProtoAlarm;     len = 38; end
      default:  begin pr = r.flag;                  len = 2;  end
    endcase
    has_pos = (r.shape == PK_LOC || r.shape == PK_ALARM);
    crc_at  = (r.shape == PK_ALARM) ? 36 : 30;
    crc     = tpp_pkg::CrcInit;
    fcs     = '0;
    q.push_back(tpp_pkg::StartByte);
    q.push_back(tpp_pkg::StartByte);
    for (int p = 0; p < len; p++) begin
      v = r.rnd ? 8'($urandom_range(0, 255)) : r.fill;
      if (p == 1) v = pr;
      if (r.shape == PK_HEART && p == 2) v = r.flag;
      if (has_pos) begin
        if (p >= 9 && p <= 12) v = r.lat[8*(12-p) +: 8];
        if (p >= 13 && p <= 16) v = r.lon[8*(16-p) +: 8];
        if (p == crc_at) begin
          fcs = ~crc;
          v   = fcs[15:8];
        end
        if (p == crc_at + 1) v = fcs[7:0] ^ {7'h00, r.bad_crc};
        if (p < crc_at) crc = crc_step(crc, v);
      end
      q.push_back(v);
    end
  endfunction

  // Offer one byte in bursts with random gaps, then track it once taken
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= b;
    do @(posedge clk_i); while (!s_ready);
    track_rx_byte(b);
  endtask

  function automatic string show(input tpp_pkg::item_t it);
    return $sformatf({"kind=%0d ack=%02h last=%0b id=%016h dt=%012h sat=%02h ",
                      "lat=%08h lon=%08h spd=%02h ok=%0b flg=%02h lvl=%04h"},
                     it.kind, it.ack_byte, it.last, it.terminal_id, it.date_time,
                     it.satellites, it.latitude, it.longitude, it.speed, it.crc_ok,
                     it.sensor_flags, it.alarm_levels);
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: check each taken item, then pick the next ready value
  initial begin : result_side
    tpp_pkg::item_t got;
    tpp_pkg::item_t want;
    int             hold_left;
    int             mode_left;
    int             ready_pct;
    logic           held_off;
    hold_left = 0;
    mode_left = 0;
    ready_pct = 100;
    held_off  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_valid && m_ready) begin
        got.kind         = m_user;
        got.last         = m_last;
        got.ack_byte     = m_data[7:0];
        got.terminal_id  = m_data[71:8];
        got.date_time    = m_data[119:72];
        got.satellites   = m_data[127:120];
        got.latitude     = m_data[159:128];
        got.longitude    = m_data[191:160];
        got.speed        = m_data[199:192];
        got.crc_ok       = m_data[200];
        got.sensor_flags = m_data[208:201];
        got.alarm_levels = m_data[224:209];
        if (due_items.size() == 0) begin
          bad_items++;
          if (bad_items <= MAX_REPORTS)
            $display("%0t: item with none due: %s", $realtime, show(got));
        end else begin
          want = due_items.pop_front();
          if (got.kind !== want.kind || got.ack_byte !== want.ack_byte ||
              got.last !== want.last || got.terminal_id !== want.terminal_id ||
              got.date_time !== want.date_time || got.satellites !== want.satellites ||
              got.latitude !== want.latitude || got.longitude !== want.longitude ||
              got.speed !== want.speed || got.crc_ok !== want.crc_ok ||
              got.sensor_flags !== want.sensor_flags ||
              got.alarm_levels !== want.alarm_levels) begin
            bad_items++;
            if (bad_items <= MAX_REPORTS) begin
              $display("%0t: item mismatch", $realtime);
              $display("  exp %s", show(want));
              $display("  got %s", show(got));
            end
          end
        end
      end
      // one long hold-off so the block fills up and stalls its input
      if (hold_go && !held_off) begin
        held_off  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 80);
        case ($urandom_range(0, 2))
          0:       ready_pct = 100;
          1:       ready_pct = 75;
          default: ready_pct = 35;
        endcase
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // Byte stream: directed packets, then random traffic
  initial begin : byte_side
    row_t    r;
    byte_q_t pkt;
    int      pick;
    int      rand_bytes;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NDIR; i++) begin
      r = DIR_ROWS[i];
      pin_valid = r.pinned;
      pin_rec   = r.rec;
      build_packet(r, pkt);
      foreach (pkt[j]) send_byte(pkt[j]);
    end

    // mostly well-formed packets with random content, some noise and junk
    hold_go <= 1'b1;
    pin_valid  = 1'b0;
    rand_bytes = 0;
    while (rand_bytes < RAND_BYTES) begin
      r    = '0;
      pick = $urandom_range(0, 99);
      if (pick < 20)      r.shape = PK_LOGIN;
      else if (pick < 40) r.shape = PK_HEART;
      else if (pick < 62) r.shape = PK_LOC;
      else if (pick < 84) r.shape = PK_ALARM;
      else if (pick < 92) r.shape = PK_UNKNOWN;
      else                r.shape = PK_NOISE;
      r.rnd     = 1'b1;
      r.lat     = $urandom;
      r.lon     = $urandom;
      r.flag    = 8'($urandom_range(0, 255));
      r.bad_crc = ($urandom_range(0, 3) == 0);
      if (r.shape == PK_UNKNOWN &&
          r.flag inside {tpp_pkg::ProtoLogin, tpp_pkg::ProtoHeartbeat,
                         tpp_pkg::ProtoLocation, tpp_pkg::ProtoAlarm})
        r.flag = r.flag ^ 8'h40;
      build_packet(r, pkt);
      foreach (pkt[j]) send_byte(pkt[j]);
      rand_bytes += pkt.size();
    end
    s_valid <= 1'b0;

    while (due_items.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_items == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/tpp_pkg.sv
sv/tpp_parser.sv
sv/tpp_emitter.sv
sv/tracker_packet_parser_responder.sv
tb/sv/tb_top.sv
